### src/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// rhsv_pkg
// shared types, constants and helpers for the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
package rhsv_pkg;

    localparam int CH_W     = 8;
    localparam int TDATA_W  = 3 * CH_W;
    localparam int DIV_BITS = 8;
    localparam int DIV_W    = 16;

    localparam logic [CH_W-1:0] HUE_OFS_RED   = 8'd0;
    localparam logic [CH_W-1:0] HUE_OFS_GREEN = 8'd85;
    localparam logic [CH_W-1:0] HUE_OFS_BLUE  = 8'd171;
    localparam logic [5:0]      HUE_SPAN      = 6'd43;

    // sector decision: max, min and the two channels of the hue difference
    typedef struct packed {
        logic [CH_W-1:0] hi;
        logic [CH_W-1:0] lo;
        logic [CH_W-1:0] dx;
        logic [CH_W-1:0] dy;
        logic [CH_W-1:0] ofs;
    } sel_t;

    // state carried through the shared restoring divider stages
    typedef struct packed {
        logic [DIV_W-1:0] rem_h;
        logic [DIV_W-1:0] rem_s;
        logic [CH_W-1:0]  q_h;
        logic [CH_W-1:0]  q_s;
        logic [CH_W-1:0]  spread;
        logic [CH_W-1:0]  hi;
        logic             neg;
        logic [CH_W-1:0]  ofs;
    } div_t;

    // divisor aligned to quotient bit k
    function automatic logic [DIV_W-1:0] align_div(input logic [CH_W-1:0] d,
                                                   input logic [2:0] k);
        logic [DIV_W-1:0] ext;
        ext = DIV_W'(d);
        return ext << k;
    endfunction

endpackage

### src/rgb_to_hsv_pixel_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_top
// 8-bit rgb pixel to 8-bit hue, saturation and value, fully pipelined
// ----------------------------------------------------------------------------
// pipeline: select, scale, eight divider stages, output register
// throughput: one pixel per cycle while m_tready is high; each divider stage
//   resolves one quotient bit of both divisions; a low m_tready stalls the pipe
// reset: aresetn low at a clock edge clears all stage valid bits; payload
//   registers are not reset
module rgb_to_hsv_pixel_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rhsv_pkg::TDATA_W-1:0]  s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rhsv_pkg::TDATA_W-1:0]  m_tdata    // hue[7:0], saturation[15:8], brightness[23:16]
);
    import rhsv_pkg::*;

    // ------------------------------------------------------------------
    // stage ready chain: a stage loads when it is empty or drains onward
    // ------------------------------------------------------------------
    logic            out_vld_reg;
    logic [TDATA_W-1:0] out_data_reg;
    logic            out_rdy;

    logic            sel_vld_reg;
    sel_t            sel_reg;
    logic            sel_rdy;

    // divider pipe: index 0 is the scaled dividends, index k after k bits
    logic            div_vld_reg [0:DIV_BITS];
    div_t            div_reg     [0:DIV_BITS];
    logic            div_rdy     [0:DIV_BITS];

    assign out_rdy = !out_vld_reg || m_tready;
    assign div_rdy[DIV_BITS] = !div_vld_reg[DIV_BITS] || out_rdy;

    genvar gi;
    generate
        for (gi = 0; gi < DIV_BITS; gi++) begin : g_rdy
            assign div_rdy[gi] = !div_vld_reg[gi] || div_rdy[gi+1];
        end
    endgenerate

    assign sel_rdy  = !sel_vld_reg || div_rdy[0];
    assign s_tready = sel_rdy;

    // ------------------------------------------------------------------
    // stage 1: max, min and sector (red wins ties, then green)
    // ------------------------------------------------------------------
    logic [CH_W-1:0] red, green, blue;
    sel_t            sel_next;

    assign red   = s_tdata[CH_W-1:0];
    assign green = s_tdata[2*CH_W-1:CH_W];
    assign blue  = s_tdata[3*CH_W-1:2*CH_W];

    always_comb begin
        sel_next = '0;
        priority if (red >= green && red >= blue) begin
            sel_next.hi  = red;
            sel_next.lo  = (green < blue) ? green : blue;
            sel_next.dx  = green;
            sel_next.dy  = blue;
            sel_next.ofs = HUE_OFS_RED;
        end else if (green >= blue) begin
            sel_next.hi  = green;
            sel_next.lo  = (red < blue) ? red : blue;
            sel_next.dx  = blue;
            sel_next.dy  = red;
            sel_next.ofs = HUE_OFS_GREEN;
        end else begin
            sel_next.hi  = blue;
            sel_next.lo  = (red < green) ? red : green;
            sel_next.dx  = red;
            sel_next.dy  = green;
            sel_next.ofs = HUE_OFS_BLUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_vld_reg <= 1'b0;
        end else if (sel_rdy) begin
            sel_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sel_rdy && s_tvalid) begin
            sel_reg <= sel_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: spread, magnitude of the difference, both dividends
    //   hue dividend = 43 * |diff|, sat dividend = 255 * spread
    // ------------------------------------------------------------------
    div_t            scl_next;
    logic [CH_W-1:0] spread;
    logic [CH_W-1:0] abs_diff;
    logic            neg;

    always_comb begin
        spread   = sel_reg.hi - sel_reg.lo;
        neg      = sel_reg.dy > sel_reg.dx;
        abs_diff = neg ? (sel_reg.dy - sel_reg.dx) : (sel_reg.dx - sel_reg.dy);
        scl_next        = '0;
        scl_next.rem_h  = DIV_W'(abs_diff) * DIV_W'(HUE_SPAN);
        scl_next.rem_s  = {spread, {CH_W{1'b0}}} - DIV_W'(spread);
        scl_next.spread = spread;
        scl_next.hi     = sel_reg.hi;
        scl_next.neg    = neg;
        scl_next.ofs    = sel_reg.ofs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_vld_reg[0] <= 1'b0;
        end else if (div_rdy[0]) begin
            div_vld_reg[0] <= sel_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_rdy[0] && sel_vld_reg) begin
            div_reg[0] <= scl_next;
        end
    end

    // ------------------------------------------------------------------
    // stages 3..10: restoring division, one quotient bit per stage for
    //   both the hue and the saturation quotient, msb first
    // ------------------------------------------------------------------
    generate
        for (gi = 0; gi < DIV_BITS; gi++) begin : g_div
            localparam logic [2:0] BIT_K = 3'(DIV_BITS - 1 - gi);

            div_t             step_next;
            logic [DIV_W-1:0] dvs_h;
            logic [DIV_W-1:0] dvs_s;

            always_comb begin
                step_next = div_reg[gi];
                dvs_h     = align_div(div_reg[gi].spread, BIT_K);
                dvs_s     = align_div(div_reg[gi].hi, BIT_K);
                if (div_reg[gi].rem_h >= dvs_h) begin
                    step_next.rem_h      = div_reg[gi].rem_h - dvs_h;
                    step_next.q_h[BIT_K] = 1'b1;
                end
                if (div_reg[gi].rem_s >= dvs_s) begin
                    step_next.rem_s      = div_reg[gi].rem_s - dvs_s;
                    step_next.q_s[BIT_K] = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    div_vld_reg[gi+1] <= 1'b0;
                end else if (div_rdy[gi+1]) begin
                    div_vld_reg[gi+1] <= div_vld_reg[gi];
                end
            end

            always_ff @(posedge aclk) begin
                if (div_rdy[gi+1] && div_vld_reg[gi]) begin
                    div_reg[gi+1] <= step_next;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // stage 11: signed hue offset, gray override, output register
    // ------------------------------------------------------------------
    div_t               fin;
    logic [CH_W-1:0]    hue_next;
    logic [CH_W-1:0]    sat_next;
    logic [TDATA_W-1:0] out_data_next;

    assign fin = div_reg[DIV_BITS];

    always_comb begin
        // gray pixel (zero spread) gives hue 0 and saturation 0
        if (fin.spread == '0) begin
            hue_next = '0;
            sat_next = '0;
        end else begin
            hue_next = fin.neg ? (fin.ofs - fin.q_h) : (fin.ofs + fin.q_h);
            sat_next = fin.q_s;
        end
        out_data_next = {fin.hi, sat_next, hue_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_rdy) begin
            out_vld_reg <= div_vld_reg[DIV_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy && div_vld_reg[DIV_BITS]) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule
